>>> sv/assert_macros.svh
// Assertion macros shared by the cache RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define SALWC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define SALWC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SALWC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define SALWC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> sv/salwc_pkg.sv
// Types, constants and helpers for the set-associative write-back cache.
package salwc_pkg;

  localparam int WAYS      = 4;
  localparam int SETS      = 256;
  localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AGE_W     = WAY_W;
  localparam int SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int INDEX_LIM = $clog2(SETS);
  localparam int ADDR_W    = 32;
  localparam int TAG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 10;
  localparam int COST_W    = 11;
  localparam int CNT_W     = 32;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_BITS    = 3'd0,
    CFG_INDEX_BITS     = 3'd1,
    CFG_HIT_COST       = 3'd2,
    CFG_MISS_COST      = 3'd3,
    CFG_WRITEBACK_COST = 3'd4
  } cfg_idx_t;

  // Control sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_LOOK
  } state_t;

  // One way of a set as held in the tag store.
  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic [TAG_W-1:0] tag;
    logic [AGE_W-1:0] age;
  } way_t;

  typedef way_t [WAYS-1:0] row_t;

  // Outcome of one lookup, handed from the update logic to the control.
  typedef struct packed {
    logic              hit;
    logic [WAY_W-1:0]  way;
    logic              writeback;
    logic [ADDR_W-1:0] evicted;
    logic [WAYS-1:0]   lru_vec;
    row_t              row_nxt;
  } upd_t;

  // Registered result item.
  typedef struct packed {
    logic              hit;
    logic [1:0]        way_used;
    logic              writeback;
    logic [ADDR_W-1:0] evicted_block;
    logic [COST_W-1:0] cost;
    logic [CNT_W-1:0]  hit_total;
    logic [CNT_W-1:0]  miss_total;
  } resp_t;

  // Contents of a set that has never been written since reset.
  function automatic row_t reset_row();
    row_t r;
    for (int w = 0; w < WAYS; w++) begin
      r[w].valid = 1'b0;
      r[w].dirty = 1'b0;
      r[w].tag   = '0;
      r[w].age   = AGE_W'(WAYS - 1 - w);
    end
    return r;
  endfunction

endpackage

>>> sv/salwc_if.sv
// Request and response channel interfaces of the cache.
interface salwc_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] address;
  logic        is_write;

  modport source (output valid, output address, output is_write, input ready);
  modport sink   (input valid, input address, input is_write, output ready);
endinterface

interface salwc_resp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [1:0]  way_used;
  logic        writeback;
  logic [31:0] evicted_block;
  logic [10:0] cost;
  logic [31:0] hit_total;
  logic [31:0] miss_total;

  modport source (output valid, output hit, output way_used, output writeback,
                  output evicted_block, output cost, output hit_total,
                  output miss_total, input ready);
  modport sink   (input valid, input hit, input way_used, input writeback,
                  input evicted_block, input cost, input hit_total,
                  input miss_total, output ready);
endinterface

>>> sv/set_assoc_lru_writeback_cache_top.sv
// A result is registered when its lookup retires, and the lookup waits while
// an earlier result is still on offer.
// A new access is taken only while the sequencer is idle, since each access
// reads and writes back one tag-store row; a result that waits holds the lookup.
// Reset: configuration returns to its defaults, counters clear and every
// set reads as empty at once through per-row flags, with no clearing pass.
`include "assert_macros.svh"

module set_assoc_lru_writeback_cache_top
  import salwc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  salwc_req_if.sink             in_ch,
  salwc_resp_if.source          out_ch
);

  state_t            state_r, state_nxt;
  logic [3:0]        offset_bits_r;
  logic [3:0]        index_bits_r;
  logic [7:0]        hit_cost_r;
  logic [9:0]        miss_cost_r;
  logic [9:0]        wb_cost_r;
  logic [CNT_W-1:0]  hit_cnt_r, hit_cnt_nxt;
  logic [CNT_W-1:0]  miss_cnt_r, miss_cnt_nxt;
  logic [TAG_W-1:0]  tag_r;
  logic [SET_W-1:0]  set_r;
  logic              wr_r;
  resp_t             out_r, out_nxt;
  logic              out_valid_r;

  logic [3:0]        ib;
  logic [ADDR_W-1:0] in_block;
  logic [ADDR_W-1:0] set_mask;
  logic [SET_W-1:0]  in_set;
  logic [TAG_W-1:0]  in_tag;
  logic              in_acc;
  logic              finish;
  logic              in_ready;
  logic [SET_W-1:0]  rd_addr;
  row_t              rd_row;
  upd_t              upd;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_bits_r <= 4'd4;
      index_bits_r  <= 4'd6;
      hit_cost_r    <= 8'd1;
      miss_cost_r   <= 10'd100;
      wb_cost_r     <= 10'd100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OFFSET_BITS:    offset_bits_r <= cfg_wdata[3:0];
        CFG_INDEX_BITS:     index_bits_r  <= cfg_wdata[3:0];
        CFG_HIT_COST:       hit_cost_r    <= cfg_wdata[7:0];
        CFG_MISS_COST:      miss_cost_r   <= cfg_wdata;
        CFG_WRITEBACK_COST: wb_cost_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Set and tag of the incoming address; the index never exceeds the store.
  assign ib       = (index_bits_r < 4'(INDEX_LIM)) ? index_bits_r : 4'(INDEX_LIM);
  assign in_block = in_ch.address >> offset_bits_r;
  assign set_mask = (ADDR_W'(1) << ib) - ADDR_W'(1);
  assign in_set   = SET_W'(in_block & set_mask);
  assign in_tag   = in_block >> ib;

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_LOOK;
      ST_LOOK: if (finish) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: take an access when idle, retire it when the result
  // register is free or being emptied.
  always_comb begin
    in_ready = 1'b0;
    finish   = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_LOOK: finish   = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  assign in_acc      = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;
  assign rd_addr     = in_acc ? in_set : set_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Access held for the lookup cycle.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      tag_r <= in_tag;
      set_r <= in_set;
      wr_r  <= in_ch.is_write;
    end
  end

  salwc_tag_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd_row  (rd_row),
    .wr_en   (finish),
    .wr_addr (set_r),
    .wr_row  (upd.row_nxt)
  );

  salwc_update u_update (
    .row      (rd_row),
    .tag      (tag_r),
    .set_idx  (set_r),
    .ib       (ib),
    .is_write (wr_r),
    .upd      (upd)
  );

  // Saturating counters and the result item.
  always_comb begin
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    if (upd.hit) begin
      if (hit_cnt_r != '1) hit_cnt_nxt = hit_cnt_r + CNT_W'(1);
    end else begin
      if (miss_cnt_r != '1) miss_cnt_nxt = miss_cnt_r + CNT_W'(1);
    end
    out_nxt.hit           = upd.hit;
    out_nxt.way_used      = 2'(upd.way);
    out_nxt.writeback     = upd.writeback;
    out_nxt.evicted_block = upd.evicted;
    out_nxt.cost          = upd.hit ? COST_W'(hit_cost_r)
                          : COST_W'(miss_cost_r)
                            + (upd.writeback ? COST_W'(wb_cost_r) : COST_W'(0));
    out_nxt.hit_total     = hit_cnt_nxt;
    out_nxt.miss_total    = miss_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (finish) begin
        hit_cnt_r   <= hit_cnt_nxt;
        miss_cnt_r  <= miss_cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_r <= out_nxt;
    end
  end

  // Result channel.
  assign out_ch.valid         = out_valid_r;
  assign out_ch.hit           = out_r.hit;
  assign out_ch.way_used      = out_r.way_used;
  assign out_ch.writeback     = out_r.writeback;
  assign out_ch.evicted_block = out_r.evicted_block;
  assign out_ch.cost          = out_r.cost;
  assign out_ch.hit_total     = out_r.hit_total;
  assign out_ch.miss_total    = out_r.miss_total;

  // The ages of a set stay a permutation, so exactly one way is oldest.
  `SALWC_ASSERT_IMPL(a_one_lru, clk, rst_n, state_r == ST_LOOK, $onehot(upd.lru_vec), "LRU age not unique")
  // A taken access is always looked up in the following cycle.
  `SALWC_ASSERT_NEXT(a_acc_look, clk, rst_n, in_acc, state_r == ST_LOOK, "access not looked up")
  // A retired access always leaves a result on offer.
  `SALWC_ASSERT_NEXT(a_fin_out, clk, rst_n, finish, out_valid_r, "retired access gave no result")
  // A hit never evicts a line.
  `SALWC_ASSERT_IMPL(a_hit_no_wb, clk, rst_n, out_valid_r, !(out_r.hit && out_r.writeback), "hit with write-back")

endmodule

>>> sv/salwc_tag_store.sv
// Tag store: one row per set holding every way, with per-row written flags.
module salwc_tag_store
  import salwc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [SET_W-1:0] rd_addr,
  output row_t             rd_row,
  input  logic             wr_en,
  input  logic [SET_W-1:0] wr_addr,
  input  row_t             wr_row
);

  row_t             mem [SETS];
  row_t             rdata_r;
  logic             rvalid_r;
  logic [SETS-1:0]  written_r;

  // Synchronous write and registered read of the row memory.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    rdata_r <= mem[rd_addr];
  end

  // Written flags: a row not yet written reads as its reset contents.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
      rvalid_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        written_r[wr_addr] <= 1'b1;
      end
      rvalid_r <= written_r[rd_addr];
    end
  end

  assign rd_row = rvalid_r ? rdata_r : reset_row();

endmodule

>>> sv/salwc_update.sv
// Hit detection, victim choice and LRU age update for one set.
module salwc_update
  import salwc_pkg::*;
(
  input  row_t             row,
  input  logic [TAG_W-1:0] tag,
  input  logic [SET_W-1:0] set_idx,
  input  logic [3:0]       ib,
  input  logic             is_write,
  output upd_t             upd
);

  logic [WAYS-1:0]  hit_vec;
  logic [WAYS-1:0]  inv_vec;
  logic [WAYS-1:0]  lru_vec;
  logic [WAY_W-1:0] hit_idx;
  logic [WAY_W-1:0] inv_idx;
  logic [WAY_W-1:0] lru_idx;
  logic [WAY_W-1:0] used;
  logic [AGE_W-1:0] old_age;
  logic             hit;
  logic             any_inv;
  logic             wb;
  row_t             row_nxt;

  // Per-way match, free and oldest flags.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w] = row[w].valid && (row[w].tag == tag);
      inv_vec[w] = !row[w].valid;
      lru_vec[w] = (row[w].age == AGE_W'(WAYS - 1));
    end
  end

  // Lowest-index selection for each flag vector.
  always_comb begin
    hit_idx = '0;
    inv_idx = '0;
    lru_idx = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) hit_idx = WAY_W'(w);
      if (inv_vec[w]) inv_idx = WAY_W'(w);
      if (lru_vec[w]) lru_idx = WAY_W'(w);
    end
  end

  assign hit     = |hit_vec;
  assign any_inv = |inv_vec;
  assign used    = hit ? hit_idx : (any_inv ? inv_idx : lru_idx);
  assign wb      = !hit && !any_inv && row[lru_idx].dirty;
  assign old_age = row[used].age;

  // New contents of the set: ages move up behind the touched way.
  always_comb begin
    row_nxt = row;
    for (int j = 0; j < WAYS; j++) begin
      if (row[j].age < old_age) begin
        row_nxt[j].age = row[j].age + AGE_W'(1);
      end
    end
    row_nxt[used].age = '0;
    if (hit) begin
      row_nxt[used].dirty = row[used].dirty | is_write;
    end else begin
      row_nxt[used].valid = 1'b1;
      row_nxt[used].dirty = is_write;
      row_nxt[used].tag   = tag;
    end
  end

  // Block address of a dirty victim rebuilt from its tag and the set.
  always_comb begin
    upd.hit       = hit;
    upd.way       = used;
    upd.writeback = wb;
    upd.evicted   = wb ? ((row[lru_idx].tag << ib) | ADDR_W'(set_idx)) : '0;
    upd.lru_vec   = lru_vec;
    upd.row_nxt   = row_nxt;
  end

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the set-associative LRU write-back cache.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import salwc_pkg::*;

  // Register values after reset.
  localparam logic [3:0] RST_OFFSET_BITS = 4'd4;
  localparam logic [3:0] RST_INDEX_BITS  = 4'd6;
  localparam logic [7:0] RST_HIT_COST    = 8'd1;
  localparam logic [9:0] RST_MISS_COST   = 10'd100;
  localparam logic [9:0] RST_WB_COST     = 10'd100;
  localparam int         RANDOM_PHASES   = 6;
  localparam int         PHASE_ACCESSES  = 175;

  typedef enum logic {ROW_ACCESS, ROW_CONFIG} row_kind_t;

  // One row of the directed stimulus: an access or a register write.
  typedef struct {
    row_kind_t  kind;
    cfg_idx_t   reg_sel;
    logic [9:0] reg_val;
    logic [31:0] addr;
    logic       store;
    bit         known;
    resp_t      want;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  salwc_req_if  in_ch();
  salwc_resp_if out_ch();

  set_assoc_lru_writeback_cache_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Shadow copy of the tag store, the counters and the registers.
  bit          line_held     [SETS][WAYS];
  bit          line_modified [SETS][WAYS];
  logic [31:0] line_key      [SETS][WAYS];
  int unsigned line_rank     [SETS][WAYS];
  logic [31:0] hits_so_far;
  logic [31:0] misses_so_far;
  logic [3:0]  cur_offset;
  logic [3:0]  cur_index;
  logic [7:0]  cur_hit_cost;
  logic [9:0]  cur_miss_cost;
  logic [9:0]  cur_wb_cost;

  resp_t       expected_results[$];
  stim_row_t   directed_rows[$];
  int          mismatch_count;
  int          results_checked;
  int          accesses_sent;
  int          writebacks_seen;
  int          hits_seen;
  int          send_idle_pct;
  int          recv_idle_pct;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit, well beyond the slowest correct run.
  initial begin
    #1_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Sets in use: the register value, but never more than the store holds.
  function automatic int unsigned set_bits();
    return (cur_index < INDEX_LIM) ? int'(cur_index) : INDEX_LIM;
  endfunction

  // Work out the outcome of one access and update the shadow store.
  function automatic resp_t predict_access(logic [31:0] a, logic store);
    resp_t       r;
    int unsigned ib;
    logic [31:0] blk;
    logic [31:0] set_no;
    logic [31:0] tag;
    int unsigned used;
    int unsigned old;
    bit          hit;
    bit          found;
    r      = '0;
    ib     = set_bits();
    blk    = a >> cur_offset;
    set_no = blk & ((32'h1 << ib) - 32'h1);
    tag    = blk >> ib;
    hit    = 1'b0;
    found  = 1'b0;
    used   = 0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && line_held[set_no][w] && line_key[set_no][w] == tag) begin
        hit  = 1'b1;
        used = w;
      end
    end
    if (hit) begin
      if (hits_so_far != '1) hits_so_far++;
      r.cost = COST_W'(cur_hit_cost);
      if (store) line_modified[set_no][used] = 1'b1;
    end else begin
      if (misses_so_far != '1) misses_so_far++;
      r.cost = COST_W'(cur_miss_cost);
      // Empty ways fill lowest first; otherwise the oldest way goes.
      for (int w = 0; w < WAYS; w++) begin
        if (!found && !line_held[set_no][w]) begin
          found = 1'b1;
          used  = w;
        end
      end
      if (!found) begin
        used = 0;
        for (int w = 1; w < WAYS; w++)
          if (line_rank[set_no][w] > line_rank[set_no][used]) used = w;
        if (line_modified[set_no][used]) begin
          r.writeback     = 1'b1;
          r.cost          = r.cost + COST_W'(cur_wb_cost);
          r.evicted_block = (line_key[set_no][used] << ib) | set_no;
        end
      end
      line_held[set_no][used]     = 1'b1;
      line_modified[set_no][used] = store;
      line_key[set_no][used]      = tag;
    end
    // The used way becomes the most recent.
    old = line_rank[set_no][used];
    for (int w = 0; w < WAYS; w++)
      if (line_rank[set_no][w] < old) line_rank[set_no][w]++;
    line_rank[set_no][used] = 0;
    r.hit        = hit;
    r.way_used   = 2'(used);
    r.hit_total  = hits_so_far;
    r.miss_total = misses_so_far;
    return r;
  endfunction

  function automatic resp_t outcome(logic h, logic [1:0] way, logic wb, logic [31:0] ev,
                                    logic [10:0] cost, logic [31:0] ht, logic [31:0] mt);
    resp_t r;
    r.hit           = h;
    r.way_used      = way;
    r.writeback     = wb;
    r.evicted_block = ev;
    r.cost          = cost;
    r.hit_total     = ht;
    r.miss_total    = mt;
    return r;
  endfunction

  function automatic stim_row_t access_row(logic [31:0] a, logic store);
    stim_row_t s;
    s.kind    = ROW_ACCESS;
    s.reg_sel = CFG_OFFSET_BITS;
    s.reg_val = '0;
    s.addr    = a;
    s.store   = store;
    s.known   = 1'b0;
    s.want    = '0;
    return s;
  endfunction

  function automatic stim_row_t known_row(logic [31:0] a, logic store, resp_t want);
    stim_row_t s;
    s       = access_row(a, store);
    s.known = 1'b1;
    s.want  = want;
    return s;
  endfunction

  function automatic stim_row_t config_row(cfg_idx_t r, logic [9:0] v);
    stim_row_t s;
    s         = access_row('0, 1'b0);
    s.kind    = ROW_CONFIG;
    s.reg_sel = r;
    s.reg_val = v;
    return s;
  endfunction

  // Random address: mostly a few tags in a few sets so that lines are
  // reused and evicted, with some fully random addresses as noise.
  function automatic logic [31:0] pick_address();
    int unsigned ib;
    logic [31:0] tag;
    logic [31:0] set_no;
    logic [31:0] low;
    logic [63:0] composed;
    if ($urandom_range(99) < 20) return $urandom();
    ib       = set_bits();
    tag      = ($urandom_range(99) < 85) ? 32'($urandom_range(5)) : $urandom();
    set_no   = 32'($urandom_range(3)) & ((32'h1 << ib) - 32'h1);
    low      = $urandom() & ((32'h1 << cur_offset) - 32'h1);
    composed = ((64'(tag) << ib) | 64'(set_no)) << cur_offset;
    return composed[31:0] | low;
  endfunction

  // Offer one access, wait for its transfer and record its expected result.
  task automatic send_access(logic [31:0] a, logic store, bit known, resp_t want);
    resp_t predicted;
    cfg_we <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.address  <= a;
    in_ch.is_write <= store;
    do @(posedge clk); while (!in_ch.ready);
    predicted = predict_access(a, store);
    expected_results.push_back(known ? want : predicted);
    accesses_sent++;
    @(negedge clk);
  endtask

  // Hold off new accesses until every outstanding result has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  // Register write; the shadow copy changes with it since the cache is idle.
  task automatic write_register(cfg_idx_t r, logic [9:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    case (r)
      CFG_OFFSET_BITS:    cur_offset    = v[3:0];
      CFG_INDEX_BITS:     cur_index     = v[3:0];
      CFG_HIT_COST:       cur_hit_cost  = v[7:0];
      CFG_MISS_COST:      cur_miss_cost = v;
      CFG_WRITEBACK_COST: cur_wb_cost   = v;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] seen);
    if (want !== seen) begin
      $display("%0t: %s differs, expected 0x%0h, actual 0x%0h", $time, name, want, seen);
      mismatch_count++;
    end
  endtask

  // Compare one result transfer with the oldest expectation.
  task automatic check_result(resp_t got);
    resp_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: result transfer with no access outstanding, actual hit=%0b way=%0d",
               $time, got.hit, got.way_used);
      mismatch_count++;
    end else begin
      want = expected_results.pop_front();
      compare_field("hit", 32'(want.hit), 32'(got.hit));
      compare_field("way_used", 32'(want.way_used), 32'(got.way_used));
      compare_field("writeback", 32'(want.writeback), 32'(got.writeback));
      compare_field("evicted_block", want.evicted_block, got.evicted_block);
      compare_field("cost", 32'(want.cost), 32'(got.cost));
      compare_field("hit_total", want.hit_total, got.hit_total);
      compare_field("miss_total", want.miss_total, got.miss_total);
    end
    results_checked++;
    if (got.writeback === 1'b1) writebacks_seen++;
    if (got.hit === 1'b1) hits_seen++;
  endtask

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      check_result(outcome(out_ch.hit, out_ch.way_used, out_ch.writeback,
                           out_ch.evicted_block, out_ch.cost, out_ch.hit_total,
                           out_ch.miss_total));
    end
  end

  // Receiver: stalls at random at the current rate.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Main sequence.
  initial begin
    logic [3:0] off;
    logic [3:0] idx;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_OFFSET_BITS;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.address  = '0;
    in_ch.is_write = 1'b0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    mismatch_count = 0;
    results_checked = 0;
    accesses_sent  = 0;
    writebacks_seen = 0;
    hits_seen      = 0;

    // Shadow state as after reset.
    for (int s = 0; s < SETS; s++) begin
      for (int w = 0; w < WAYS; w++) begin
        line_held[s][w]     = 1'b0;
        line_modified[s][w] = 1'b0;
        line_key[s][w]      = '0;
        line_rank[s][w]     = WAYS - 1 - w;
      end
    end
    hits_so_far   = '0;
    misses_so_far = '0;
    cur_offset    = RST_OFFSET_BITS;
    cur_index     = RST_INDEX_BITS;
    cur_hit_cost  = RST_HIT_COST;
    cur_miss_cost = RST_MISS_COST;
    cur_wb_cost   = RST_WB_COST;

    // Default settings: fill one set, evict dirty lines, address extremes.
    directed_rows.push_back(known_row(32'h0000_0000, 1'b0,
                                      outcome(1'b0, 2'd0, 1'b0, '0, 11'd100, 0, 1)));
    directed_rows.push_back(known_row(32'h0000_0000, 1'b1,
                                      outcome(1'b1, 2'd0, 1'b0, '0, 11'd1, 1, 1)));
    directed_rows.push_back(known_row(32'h0000_0400, 1'b1,
                                      outcome(1'b0, 2'd1, 1'b0, '0, 11'd100, 1, 2)));
    directed_rows.push_back(known_row(32'h0000_0800, 1'b0,
                                      outcome(1'b0, 2'd2, 1'b0, '0, 11'd100, 1, 3)));
    directed_rows.push_back(known_row(32'h0000_0C00, 1'b1,
                                      outcome(1'b0, 2'd3, 1'b0, '0, 11'd100, 1, 4)));
    // Set full: the oldest way is dirty, so it is written back.
    directed_rows.push_back(known_row(32'h0000_1000, 1'b0,
                                      outcome(1'b0, 2'd0, 1'b1, 32'h0, 11'd200, 1, 5)));
    directed_rows.push_back(known_row(32'h0000_1400, 1'b0,
                                      outcome(1'b0, 2'd1, 1'b1, 32'h40, 11'd200, 1, 6)));
    directed_rows.push_back(known_row(32'hFFFF_FFFF, 1'b1,
                                      outcome(1'b0, 2'd0, 1'b0, '0, 11'd100, 1, 7)));
    directed_rows.push_back(known_row(32'hFFFF_FFF0, 1'b0,
                                      outcome(1'b1, 2'd0, 1'b0, '0, 11'd1, 2, 7)));
    directed_rows.push_back(access_row(32'h0000_0800, 1'b0));
    // Largest offset, index wider than the store, largest costs; lines kept.
    directed_rows.push_back(config_row(CFG_OFFSET_BITS, 10'd15));
    directed_rows.push_back(config_row(CFG_INDEX_BITS, 10'd12));
    directed_rows.push_back(config_row(CFG_HIT_COST, 10'd255));
    directed_rows.push_back(config_row(CFG_MISS_COST, 10'd1023));
    directed_rows.push_back(config_row(CFG_WRITEBACK_COST, 10'd1023));
    // Victim block rebuilt under the new layout, at the largest cost.
    directed_rows.push_back(known_row(32'h0000_0000, 1'b1,
                                      outcome(1'b0, 2'd3, 1'b1, 32'h300, 11'd2046, 3, 8)));
    directed_rows.push_back(access_row(32'h0000_7FFF, 1'b0));
    directed_rows.push_back(access_row(32'h0080_0000, 1'b1));
    directed_rows.push_back(access_row(32'hFFFF_8000, 1'b1));
    directed_rows.push_back(access_row(32'h7FFF_FFFF, 1'b0));
    // Smallest settings: one set, tag is the whole address, zero costs.
    directed_rows.push_back(config_row(CFG_OFFSET_BITS, 10'd0));
    directed_rows.push_back(config_row(CFG_INDEX_BITS, 10'd0));
    directed_rows.push_back(config_row(CFG_HIT_COST, 10'd0));
    directed_rows.push_back(config_row(CFG_MISS_COST, 10'd0));
    directed_rows.push_back(config_row(CFG_WRITEBACK_COST, 10'd0));
    directed_rows.push_back(access_row(32'hFFFF_FFFF, 1'b1));
    directed_rows.push_back(access_row(32'h0000_0000, 1'b1));
    directed_rows.push_back(access_row(32'h0000_0001, 1'b1));
    directed_rows.push_back(access_row(32'h0000_0002, 1'b0));
    directed_rows.push_back(access_row(32'hFFFF_FFFE, 1'b1));
    directed_rows.push_back(access_row(32'hFFFF_FFFF, 1'b0));

    // Reset, released on a falling edge.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CONFIG) begin
        drain_results();
        write_register(directed_rows[i].reg_sel, directed_rows[i].reg_val);
      end else begin
        send_access(directed_rows[i].addr, directed_rows[i].store,
                    directed_rows[i].known, directed_rows[i].want);
      end
    end

    // Random part: a new setting per phase, idling pattern per pair of phases.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p / 2)
        0: begin send_idle_pct = 26; recv_idle_pct = 59; end
        1: begin send_idle_pct = 59; recv_idle_pct = 26; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      drain_results();
      off = (p == 0) ? RST_OFFSET_BITS : 4'($urandom_range(15));
      idx = 4'($urandom_range(15));
      write_register(CFG_OFFSET_BITS, 10'(off));
      write_register(CFG_INDEX_BITS, 10'(idx));
      write_register(CFG_HIT_COST, 10'($urandom_range(255)));
      write_register(CFG_MISS_COST, 10'($urandom_range(1023)));
      write_register(CFG_WRITEBACK_COST, 10'($urandom_range(1023)));
      for (int i = 0; i < PHASE_ACCESSES; i++) begin
        // Halfway through, let the pipeline empty completely.
        if (i == PHASE_ACCESSES / 2) drain_results();
        send_access(pick_address(), 1'($urandom_range(1)), 1'b0, '0);
      end
    end

    // Wind down and give any stray result time to show.
    drain_results();
    cfg_we <= 1'b0;
    repeat (10) @(negedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      mismatch_count++;
    end

    $display("Covered %0d accesses (%0d directed rows) over %0d random settings.",
             accesses_sent, directed_rows.size(), RANDOM_PHASES);
    $display("Checked %0d results: %0d hits, %0d write-backs, %0d field errors.",
             results_checked, hits_seen, writebacks_seen, mismatch_count);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
